>>> design/julia_escape_time_pixel_top_assert.svh
// Assertion macros for the Julia escape-time pixel block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef JULIA_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define JETP_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("jetp assertion failed");

// Next-cycle implication.
`define JETP_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("jetp assertion failed");

`else

`define JETP_ASSERT_IMP(name, pre, post)
`define JETP_ASSERT_NXT(name, pre, post)

`endif

`endif

>>> design/jetp_pkg.sv
package jetp_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_C_REAL       = 3'd0,
        CFG_C_IMAG       = 3'd1,
        CFG_X_ORIGIN     = 3'd2,
        CFG_Y_ORIGIN     = 3'd3,
        CFG_PIXEL_STEP   = 3'd4,
        CFG_ESCAPE_LIMIT = 3'd5,
        CFG_EARLY_ITERS  = 3'd6
    } jetp_cfg_idx_t;

    typedef struct packed {
        logic [11:0] pixel_column;
        logic [11:0] pixel_row;
    } jetp_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] escape_iteration;
    } jetp_out_t;

    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
        logic signed [31:0] x_origin;
        logic signed [31:0] y_origin;
        logic [30:0]        pixel_step;
        logic [30:0]        escape_limit;
        logic [7:0]         early_escape_iters;
    } jetp_cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic load_pixel;
        logic map_mul;
        logic map_add;
        logic square;
        logic update;
        logic load_out;
    } jetp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic escaped;
        logic last;
    } jetp_sts_t;

    // Colours
    localparam logic [7:0] RED_ESCAPED  = 8'd200;
    localparam logic [7:0] RED_INSIDE   = 8'd255;
    localparam logic [7:0] GREEN_INSIDE = 8'd100;

    // trunc(sin(k)*8.5), negatives clamped to zero
    localparam logic [7:0] SINE_BLUE [64] = '{
        8'd0, 8'd7, 8'd7, 8'd1, 8'd0, 8'd0, 8'd0, 8'd5,
        8'd8, 8'd3, 8'd0, 8'd0, 8'd0, 8'd3, 8'd8, 8'd5,
        8'd0, 8'd0, 8'd0, 8'd1, 8'd7, 8'd7, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd6, 8'd8, 8'd2, 8'd0, 8'd0, 8'd0,
        8'd4, 8'd8, 8'd4, 8'd0, 8'd0, 8'd0, 8'd2, 8'd8,
        8'd6, 8'd0, 8'd0, 8'd0, 8'd0, 8'd7, 8'd7, 8'd1,
        8'd0, 8'd0, 8'd0, 8'd5, 8'd8, 8'd3, 8'd0, 8'd0,
        8'd0, 8'd3, 8'd8, 8'd5, 8'd0, 8'd0, 8'd0, 8'd1
    };

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> design/julia_escape_time_pixel_top.sv
// Julia escape-time pixel: after an input transfer the pixel is mapped (multiply, add), then
// each step of z = z*z + c runs as a square state and an update state until escape or the
// iteration limit, and the result is loaded into the output register. A new pixel is taken
// only once the previous one has been handed to the output register.
// Reset (rst_n, asynchronous, active low) clears the controller and the output valid
// and loads every configuration register with its documented default.
module julia_escape_time_pixel_top
    import jetp_pkg::*;
#(
    parameter int ITERATIONS    = 200,
    parameter int IMAGE_SIZE    = 4096,
    parameter int FRACTION_BITS = 28
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // pixel input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  jetp_in_t               in_data,
    // colour result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output jetp_out_t              out_data,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    jetp_cfg_t cfg;
    jetp_cmd_t cmd;
    jetp_sts_t sts;

    // Configuration registers; a transfer to an index past the list is dropped.
    jetp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer: map (multiply, add), then alternate square and update until
    // escape or the iteration limit, then hand over to the output register.
    // The output register lets the next pixel start while a result waits.
    jetp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: pixel mapping, three 32x32 products per step, saturating
    // update, |z|^2 compare, and colouring from the sine table.
    jetp_datapath
    #(
        .ITERATIONS    (ITERATIONS),
        .IMAGE_SIZE    (IMAGE_SIZE),
        .FRACTION_BITS (FRACTION_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .cfg      (cfg),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

>>> design/jetp_cfg_regs.sv
module jetp_cfg_regs
    import jetp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output jetp_cfg_t              cfg
);

    jetp_cfg_t cfg_reg;
    jetp_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_C_REAL:       cfg_next.c_real             = cfg_data;
                CFG_C_IMAG:       cfg_next.c_imag             = cfg_data;
                CFG_X_ORIGIN:     cfg_next.x_origin           = cfg_data;
                CFG_Y_ORIGIN:     cfg_next.y_origin           = cfg_data;
                CFG_PIXEL_STEP:   cfg_next.pixel_step         = cfg_data[30:0];
                CFG_ESCAPE_LIMIT: cfg_next.escape_limit       = cfg_data[30:0];
                CFG_EARLY_ITERS:  cfg_next.early_escape_iters = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.c_real             <= -32'sd18771692;
            cfg_reg.c_imag             <= -32'sd178611584;
            cfg_reg.x_origin           <= -32'sd348966093;
            cfg_reg.y_origin           <= -32'sd348966093;
            cfg_reg.pixel_step         <= 31'd174483;
            cfg_reg.escape_limit       <= 31'd453655921;
            cfg_reg.early_escape_iters <= 8'd6;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/jetp_datapath.sv
module jetp_datapath
    import jetp_pkg::*;
#(
    parameter int ITERATIONS    = 200,
    parameter int IMAGE_SIZE    = 4096,
    parameter int FRACTION_BITS = 28
)
(
    input  logic      clk,
    input  jetp_cfg_t cfg,
    input  jetp_in_t  in_data,
    input  jetp_cmd_t cmd,
    output jetp_sts_t sts,
    output jetp_out_t out_data
);

    localparam int IDX_W  = $clog2(ITERATIONS);
    localparam int DIV    = 4 * ITERATIONS;
    localparam int K_INC  = 255 / DIV;
    localparam int K_REM  = 255 % DIV;
    localparam int ACC_W  = $clog2(DIV);

    logic [11:0]        col_reg, row_reg;
    logic [42:0]        mx_reg, my_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [63:0] xx_reg, yy_reg, xy_reg;
    logic               stepped_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [5:0]         k_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic               res_escaped_reg;
    logic [IDX_W-1:0]   res_idx_reg;
    logic [5:0]         res_k_reg;
    jetp_out_t          out_reg;
    jetp_out_t          out_next;

    logic [11:0]        col_c, row_c;
    logic signed [43:0] x_map, y_map;
    logic signed [63:0] xx_c, yy_c, xy_c;
    logic signed [63:0] nx, ny;
    logic [63:0]        mag;
    logic               mag_gt;
    logic [ACC_W:0]     acc_sum;
    logic               early;

    // clamp indices outside the image
    assign col_c = ({20'd0, in_data.pixel_column} >= 32'(IMAGE_SIZE)) ?
                   12'(IMAGE_SIZE - 1) : in_data.pixel_column;
    assign row_c = ({20'd0, in_data.pixel_row} >= 32'(IMAGE_SIZE)) ?
                   12'(IMAGE_SIZE - 1) : in_data.pixel_row;

    assign x_map = 44'(cfg.x_origin) + $signed({1'b0, mx_reg});
    assign y_map = 44'(cfg.y_origin) + $signed({1'b0, my_reg});

    assign xx_c = 64'(x_reg) * 64'(x_reg);
    assign yy_c = 64'(y_reg) * 64'(y_reg);
    assign xy_c = 64'(x_reg) * 64'(y_reg);

    assign nx = (xx_reg >>> FRACTION_BITS) - (yy_reg >>> FRACTION_BITS) + 64'(cfg.c_real);
    assign ny = (xy_reg >>> (FRACTION_BITS - 1)) + 64'(cfg.c_imag);

    // squares are non-negative, so the unsigned sum cannot wrap
    assign mag    = (unsigned'(xx_reg) + unsigned'(yy_reg)) >> FRACTION_BITS;
    assign mag_gt = mag > {33'd0, cfg.escape_limit};

    assign sts.escaped = stepped_reg && mag_gt;
    assign sts.last    = stepped_reg && (idx_reg == IDX_W'(ITERATIONS - 1));

    assign acc_sum = {1'b0, acc_reg} + (ACC_W+1)'(K_REM);

    assign early = 32'(res_idx_reg) < 32'(cfg.early_escape_iters);

    always_comb
    begin
        if (!res_escaped_reg)
        begin
            out_next.red              = RED_INSIDE;
            out_next.green            = GREEN_INSIDE;
            out_next.blue             = 8'd0;
            out_next.escape_iteration = 8'(ITERATIONS);
        end
        else if (early)
        begin
            out_next.red              = 8'd0;
            out_next.green            = 8'd0;
            out_next.blue             = 8'd0;
            out_next.escape_iteration = 8'(res_idx_reg);
        end
        else
        begin
            out_next.red              = RED_ESCAPED;
            out_next.green            = 8'd0;
            out_next.blue             = SINE_BLUE[res_k_reg];
            out_next.escape_iteration = 8'(res_idx_reg);
        end
    end

    assign out_data = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            col_reg     <= col_c;
            row_reg     <= row_c;
            stepped_reg <= 1'b0;
            idx_reg     <= '0;
            k_reg       <= '0;
            acc_reg     <= '0;
        end
        if (cmd.map_mul)
        begin
            mx_reg <= 43'(col_reg) * 43'(cfg.pixel_step);
            my_reg <= 43'(row_reg) * 43'(cfg.pixel_step);
        end
        if (cmd.map_add)
        begin
            x_reg <= sat32(64'(x_map));
            y_reg <= sat32(64'(y_map));
        end
        if (cmd.square)
        begin
            xx_reg <= xx_c;
            yy_reg <= yy_c;
            xy_reg <= xy_c;
        end
        if (cmd.update)
        begin
            if (sts.escaped)
            begin
                res_escaped_reg <= 1'b1;
                res_idx_reg     <= idx_reg;
                res_k_reg       <= k_reg;
            end
            else if (sts.last)
            begin
                res_escaped_reg <= 1'b0;
            end
            else
            begin
                x_reg <= sat32(nx);
                y_reg <= sat32(ny);
                if (stepped_reg)
                begin
                    idx_reg <= idx_reg + 1'b1;
                    // k tracks floor(idx*255/DIV) without a divider
                    if (acc_sum >= (ACC_W+1)'(DIV))
                    begin
                        acc_reg <= ACC_W'(acc_sum - (ACC_W+1)'(DIV));
                        k_reg   <= k_reg + 6'(K_INC + 1);
                    end
                    else
                    begin
                        acc_reg <= acc_sum[ACC_W-1:0];
                        k_reg   <= k_reg + 6'(K_INC);
                    end
                end
                else
                begin
                    stepped_reg <= 1'b1;
                end
            end
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

endmodule

>>> design/jetp_ctrl.sv
`include "julia_escape_time_pixel_top_assert.svh"

module jetp_ctrl
    import jetp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  jetp_sts_t sts,
    output jetp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_ADD,
        ST_SQUARE,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.load_pixel = in_valid && in_ready;
    assign cmd.map_mul    = (state_reg == ST_MAP_MUL);
    assign cmd.map_add    = (state_reg == ST_MAP_ADD);
    assign cmd.square     = (state_reg == ST_SQUARE);
    assign cmd.update     = (state_reg == ST_UPDATE);
    assign cmd.load_out   = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_MAP_MUL;
            ST_MAP_MUL: state_next = ST_MAP_ADD;
            ST_MAP_ADD: state_next = ST_SQUARE;
            ST_SQUARE:  state_next = ST_UPDATE;
            ST_UPDATE:  state_next = (sts.escaped || sts.last) ? ST_FINISH : ST_SQUARE;
            ST_FINISH:  if (cmd.load_out) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // one pixel in flight
    `JETP_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // a finished pixel always reaches the result register
    `JETP_ASSERT_NXT(a_load_sets_valid, cmd.load_out, out_valid)
    // end of iteration always leads to the finish step
    `JETP_ASSERT_NXT(a_update_ends, (state_reg == ST_UPDATE) && (sts.escaped || sts.last),
                     (state_reg == ST_FINISH))
    // a waiting result is never overwritten
    `JETP_ASSERT_IMP(a_no_overwrite, cmd.load_out && out_valid, out_ready)

endmodule
